FILE: src/look_at_matrix_builder_top_assert.svh
// Assertion macros for the look-at matrix builder.
// Each macro takes a label, a condition, a consequence and a message.
`ifndef LOOK_AT_MATRIX_BUILDER_TOP_ASSERT_SVH
`define LOOK_AT_MATRIX_BUILDER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LAMB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LAMB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LAMB_ASSERT_IMP(lbl, ante, cons, msg)
`define LAMB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: src/lamb_pkg.sv
// ----------------------------------------------------------------------------
// lamb_pkg
// Types and constants shared by the look-at matrix builder.
// ----------------------------------------------------------------------------
`default_nettype none
package lamb_pkg;

  // matrix row codes
  typedef enum logic [1:0] {
    ROW_RIGHT = 2'd0,
    ROW_UP    = 2'd1,
    ROW_FWD   = 2'd2,
    ROW_TRANS = 2'd3
  } row_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_UP_X    = 2'd0,
    CFG_UP_Y    = 2'd1,
    CFG_UP_Z    = 2'd2,
    CFG_USE_ABS = 2'd3
  } cfg_reg_t;

  localparam int VEC_W    = 34;  // eye vector, exact difference width
  localparam int MAG_W    = 33;  // magnitude of a vector component
  localparam int NORM_MSB = 29;  // largest magnitude lands in [2^29, 2^30)
  localparam int SQ_W     = 30;  // scaled magnitude
  localparam int SUM_W    = 62;  // sum of squares
  localparam int ROOT_W   = 31;  // square root
  localparam int REM_W    = 34;  // square root remainder
  localparam int POS_W    = 6;   // bit position of a magnitude

  // scaled magnitudes and signs carried beside the root and divide stages
  typedef struct packed {
    logic [2:0]            sgn;
    logic                  zero;
    logic [2:0][SQ_W-1:0]  mag;
  } side_t;

  // stages of the normalizer: 5 front stages, root, divide, sign
  function automatic int norm_latency(input int frac);
    return frac + ROOT_W + 7;
  endfunction

endpackage
`default_nettype wire

FILE: src/lamb_norm.sv
// ----------------------------------------------------------------------------
// lamb_norm
// Pipelined vector normalizer: scale, square, sum, bit-per-stage square root,
// then bit-per-stage division of each scaled magnitude by the root.
// ----------------------------------------------------------------------------
`default_nettype none
module lamb_norm import lamb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [VEC_W-1:0]     vec_in [3],
  output logic signed [FRAC_BITS+1:0]      unit_out [3]
);

  localparam int QW = FRAC_BITS + 1;
  localparam int DW = ROOT_W + FRAC_BITS + 2;

  // stage 1: magnitudes and signs
  logic [MAG_W-1:0] mag1 [3];
  logic [2:0]       sgn1;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sgn1[i] <= vec_in[i][VEC_W-1];
        mag1[i] <= vec_in[i][VEC_W-1] ? MAG_W'(-vec_in[i]) : MAG_W'(vec_in[i]);
      end
    end
  end

  // stage 2: largest magnitude and its leading bit
  logic [MAG_W-1:0] mx;
  logic [POS_W-1:0] pos;
  always_comb begin
    mx = mag1[0];
    if (mag1[1] > mx) mx = mag1[1];
    if (mag1[2] > mx) mx = mag1[2];
    pos = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (mx[b]) pos = POS_W'(b);
    end
  end

  logic [MAG_W-1:0] mag2 [3];
  logic [2:0]       sgn2;
  logic [POS_W-1:0] pos2;
  logic             zero2;
  always_ff @(posedge clk) begin
    if (en) begin
      mag2  <= mag1;
      sgn2  <= sgn1;
      pos2  <= pos;
      zero2 <= (mx == '0);
    end
  end

  // stage 3: common shift into the normalized range
  side_t side3;
  always_ff @(posedge clk) begin
    if (en) begin
      side3.sgn  <= sgn2;
      side3.zero <= zero2;
      for (int i = 0; i < 3; i++) begin
        if (pos2 < POS_W'(NORM_MSB)) begin
          side3.mag[i] <= SQ_W'(mag2[i] << (POS_W'(NORM_MSB) - pos2));
        end else begin
          side3.mag[i] <= SQ_W'(mag2[i] >> (pos2 - POS_W'(NORM_MSB)));
        end
      end
    end
  end

  // stage 4: squares
  side_t           side4;
  logic [2*SQ_W-1:0] sq4 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      side4 <= side3;
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= side3.mag[i] * side3.mag[i];
      end
    end
  end

  // stage 5: sum of squares
  side_t            side5;
  logic [SUM_W-1:0] sum5;
  always_ff @(posedge clk) begin
    if (en) begin
      side5 <= side4;
      sum5  <= SUM_W'(sq4[0]) + SUM_W'(sq4[1]) + SUM_W'(sq4[2]);
    end
  end

  // square root, one result bit per stage
  logic [SUM_W-1:0]  sx    [ROOT_W+1];
  logic [REM_W-1:0]  srem  [ROOT_W+1];
  logic [ROOT_W-1:0] sroot [ROOT_W+1];
  side_t             sside [ROOT_W+1];

  assign sx[0]    = sum5;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sside[0] = side5;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam int B = ROOT_W - 1 - k;
    logic [REM_W-1:0] r_try;
    logic [REM_W-1:0] trial;
    always_comb begin
      r_try = {srem[k][REM_W-3:0], sx[k][2*B+1 -: 2]};
      trial = REM_W'({sroot[k], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sx[k+1]    <= sx[k];
        sside[k+1] <= sside[k];
        if (r_try >= trial) begin
          srem[k+1]  <= r_try - trial;
          sroot[k+1] <= {sroot[k][ROOT_W-2:0], 1'b1};
        end else begin
          srem[k+1]  <= r_try;
          sroot[k+1] <= {sroot[k][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // rounded division of each magnitude by the root, one quotient bit per stage
  logic [DW-1:0]     drem [QW+1][3];
  logic [QW-1:0]     dq   [QW+1][3];
  logic [ROOT_W-1:0] dn   [QW+1];
  side_t             dside[QW+1];

  assign dn[0]    = sroot[ROOT_W];
  assign dside[0] = sside[ROOT_W];
  for (genvar i = 0; i < 3; i++) begin : g_num
    assign drem[0][i] = (DW'(sside[ROOT_W].mag[i]) << FRAC_BITS)
                      + DW'(sroot[ROOT_W] >> 1);
    assign dq[0][i]   = '0;
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int K = FRAC_BITS - j;
    logic [DW-1:0] dsub;
    assign dsub = DW'(dn[j]) << K;
    always_ff @(posedge clk) begin
      if (en) begin
        dn[j+1]    <= dn[j];
        dside[j+1] <= dside[j];
        for (int i = 0; i < 3; i++) begin
          if (drem[j][i] >= dsub) begin
            drem[j+1][i] <= drem[j][i] - dsub;
            dq[j+1][i]   <= {dq[j][i][QW-2:0], 1'b1};
          end else begin
            drem[j+1][i] <= drem[j][i];
            dq[j+1][i]   <= {dq[j][i][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // sign and zero-length handling
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dside[QW].zero) begin
          unit_out[i] <= '0;
        end else if (dside[QW].sgn[i]) begin
          unit_out[i] <= -$signed({1'b0, dq[QW][i]});
        end else begin
          unit_out[i] <= $signed({1'b0, dq[QW][i]});
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/lamb_cross.sv
// ----------------------------------------------------------------------------
// lamb_cross
// Two-stage cross product right = up x forward, with floor shift.
// Forward is negated on entry.
// ----------------------------------------------------------------------------
`default_nettype none
module lamb_cross import lamb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic signed [FRAC_BITS+1:0] up_in [3],
  input  wire logic signed [FRAC_BITS+1:0] eye_in [3],
  output logic signed [31:0]              right_out [3],
  output logic signed [31:0]              up_out [3],
  output logic signed [31:0]              fwd_out [3]
);

  localparam int UW = FRAC_BITS + 2;
  localparam int PW = 2 * UW;

  // stage 1: negate forward, six products
  logic signed [UW-1:0] up1 [3];
  logic signed [UW-1:0] fw1 [3];
  logic signed [PW-1:0] pr1 [6];
  logic signed [UW-1:0] fw0 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) fw0[i] = -eye_in[i];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      up1    <= up_in;
      fw1    <= fw0;
      pr1[0] <= up_in[1] * fw0[2];
      pr1[1] <= up_in[2] * fw0[1];
      pr1[2] <= up_in[2] * fw0[0];
      pr1[3] <= up_in[0] * fw0[2];
      pr1[4] <= up_in[0] * fw0[1];
      pr1[5] <= up_in[1] * fw0[0];
    end
  end

  // stage 2: differences, arithmetic shift floors toward minus infinity
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        up_out[i]  <= 32'(up1[i]);
        fwd_out[i] <= 32'(fw1[i]);
        right_out[i] <= 32'((PW+1)'(pr1[2*i]) - (PW+1)'(pr1[2*i+1]) >>> FRAC_BITS);
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/look_at_matrix_builder_top.sv
// ----------------------------------------------------------------------------
// look_at_matrix_builder_top
// Builds look-at matrix rows (right, up, forward, translation) per item.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | target, own_abs, parent, rel (x, y, z)
//  out     | out_valid / out_ready| row_index, col0..col3, last_row
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each item yields four rows on the output, one per cycle while out_ready
// is high, and the output register loads the next item as its last row
// is accepted. The pipeline stalls as a whole while the last stage cannot
// load the output register. Reset clears valid bits and sets the up vector
// to (0, 1.0, 0) with absolute mode.
`default_nettype none
module look_at_matrix_builder_top import lamb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic signed [31:0] target_x,
  input  wire logic signed [31:0] target_y,
  input  wire logic signed [31:0] target_z,
  input  wire logic signed [31:0] own_abs_x,
  input  wire logic signed [31:0] own_abs_y,
  input  wire logic signed [31:0] own_abs_z,
  input  wire logic signed [31:0] parent_x,
  input  wire logic signed [31:0] parent_y,
  input  wire logic signed [31:0] parent_z,
  input  wire logic signed [31:0] rel_x,
  input  wire logic signed [31:0] rel_y,
  input  wire logic signed [31:0] rel_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       row_index,
  output logic signed [31:0] col0,
  output logic signed [31:0] col1,
  output logic signed [31:0] col2,
  output logic signed [31:0] col3,
  output logic             last_row,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

`include "look_at_matrix_builder_top_assert.svh"

  localparam int D  = norm_latency(FRAC_BITS) + 2;
  localparam int UW = FRAC_BITS + 2;

  // configuration registers
  logic signed [31:0] up_x, up_y, up_z;
  logic               use_absolute;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      up_x         <= '0;
      up_y         <= 32'(1) << FRAC_BITS;
      up_z         <= '0;
      use_absolute <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_UP_X:    up_x <= cfg_data;
        CFG_UP_Y:    up_y <= cfg_data;
        CFG_UP_Z:    up_z <= cfg_data;
        CFG_USE_ABS: use_absolute <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // pipeline control
  logic       adv, load, ofull;
  row_t       row;
  logic       vpipe [D+1];
  logic signed [31:0] ppipe [D+1][3];
  assign load     = !ofull || (out_ready && row == ROW_TRANS);
  assign adv      = !vpipe[D] || load;
  assign in_ready = adv;

  // input stage: eye vector, translation, up snapshot
  logic signed [VEC_W-1:0] eye0 [3];
  logic signed [VEC_W-1:0] up0  [3];
  logic signed [31:0] tg [3], ab [3], pa [3], rl [3];
  always_comb begin
    tg = '{target_x, target_y, target_z};
    ab = '{own_abs_x, own_abs_y, own_abs_z};
    pa = '{parent_x, parent_y, parent_z};
    rl = '{rel_x, rel_y, rel_z};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe[0] <= 1'b0;
    end else if (adv) begin
      vpipe[0] <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      up0[0] <= VEC_W'(up_x);
      up0[1] <= VEC_W'(up_y);
      up0[2] <= VEC_W'(up_z);
      for (int i = 0; i < 3; i++) begin
        if (use_absolute) begin
          eye0[i]     <= VEC_W'(tg[i]) - VEC_W'(ab[i]);
          ppipe[0][i] <= ab[i];
        end else begin
          eye0[i]     <= VEC_W'(tg[i]) - VEC_W'(pa[i]) - VEC_W'(rl[i]);
          ppipe[0][i] <= rl[i];
        end
      end
    end
  end

  // valid bits and translation travel beside the math
  for (genvar k = 0; k < D; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        vpipe[k+1] <= 1'b0;
      end else if (adv) begin
        vpipe[k+1] <= vpipe[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) ppipe[k+1] <= ppipe[k];
    end
  end

  // normalizers and cross product
  logic signed [UW-1:0] eye_n [3];
  logic signed [UW-1:0] up_n  [3];
  logic signed [31:0]   rt_c [3], up_c [3], fw_c [3];

  lamb_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_eye (
    .clk(clk), .en(adv), .vec_in(eye0), .unit_out(eye_n)
  );
  lamb_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_up (
    .clk(clk), .en(adv), .vec_in(up0), .unit_out(up_n)
  );
  lamb_cross #(.FRAC_BITS(FRAC_BITS)) u_cross (
    .clk(clk), .en(adv), .up_in(up_n), .eye_in(eye_n),
    .right_out(rt_c), .up_out(up_c), .fwd_out(fw_c)
  );

  // output register, four rows per item
  logic signed [31:0] o_rt [3], o_up [3], o_fw [3], o_ps [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      ofull <= 1'b0;
      row   <= ROW_RIGHT;
    end else if (vpipe[D] && load) begin
      ofull <= 1'b1;
      row   <= ROW_RIGHT;
    end else if (ofull && out_ready) begin
      if (row == ROW_TRANS) begin
        ofull <= 1'b0;
        row   <= ROW_RIGHT;
      end else begin
        row <= row_t'(row + 2'd1);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (vpipe[D] && load) begin
      o_rt <= rt_c;
      o_up <= up_c;
      o_fw <= fw_c;
      o_ps <= ppipe[D];
    end
  end

  // row selection
  assign out_valid = ofull;
  assign row_index = row;
  assign last_row  = (row == ROW_TRANS);
  always_comb begin
    unique case (row)
      ROW_RIGHT: begin
        col0 = o_rt[0]; col1 = o_rt[1]; col2 = o_rt[2]; col3 = '0;
      end
      ROW_UP: begin
        col0 = o_up[0]; col1 = o_up[1]; col2 = o_up[2]; col3 = '0;
      end
      ROW_FWD: begin
        col0 = o_fw[0]; col1 = o_fw[1]; col2 = o_fw[2]; col3 = '0;
      end
      default: begin
        col0 = o_ps[0]; col1 = o_ps[1]; col2 = o_ps[2];
        col3 = 32'(1) << FRAC_BITS;
      end
    endcase
  end

  // checks
  `LAMB_ASSERT_NXT(a_row_step, ofull && out_ready && (row != ROW_TRANS), ofull && (row == row_t'($past(row) + 2'd1)), "row sequence broken")
  `LAMB_ASSERT_IMP(a_idle_row, !ofull, row == ROW_RIGHT, "row counter not at start while empty")
  `LAMB_ASSERT_NXT(a_stall_keep, vpipe[D] && !load, vpipe[D], "pending item lost during stall")

endmodule
`default_nettype wire

FILE: verif/look_at_matrix_builder_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// look_at_matrix_builder_top_test
// Drives target and position items through the look-at matrix builder under
// random burst and stall patterns, predicts the four matrix rows of each item
// in fixed point and compares every row field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module look_at_matrix_builder_top_test import lamb_pkg::*; ();

  localparam int FRAC = 16;
  localparam int LATENCY = FRAC + 42;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] tgt [3];
    logic signed [31:0] abs_pos [3];
    logic signed [31:0] par [3];
    logic signed [31:0] rel [3];
  } look_item_t;

  typedef struct {
    row_t               row;
    logic signed [31:0] c0, c1, c2, c3;
    logic               last;
  } matrix_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
  logic signed [31:0] own_abs_x = '0, own_abs_y = '0, own_abs_z = '0;
  logic signed [31:0] parent_x = '0, parent_y = '0, parent_z = '0;
  logic signed [31:0] rel_x = '0, rel_y = '0, rel_z = '0;
  logic out_valid, out_ready = 1'b0;
  logic [1:0] row_index;
  logic signed [31:0] col0, col1, col2, col3;
  logic last_row;
  logic cfg_valid = 1'b0, cfg_ready;
  cfg_reg_t cfg_index = CFG_UP_X;
  logic [31:0] cfg_data = '0;

  always #1 clk = ~clk;

  look_at_matrix_builder_top #(.FRAC_BITS(FRAC)) i_dut (
    .clk, .rst, .in_valid, .in_ready,
    .target_x, .target_y, .target_z, .own_abs_x, .own_abs_y, .own_abs_z,
    .parent_x, .parent_y, .parent_z, .rel_x, .rel_y, .rel_z,
    .out_valid, .out_ready, .row_index, .col0, .col1, .col2, .col3, .last_row,
    .cfg_valid, .cfg_ready, .cfg_index(cfg_index), .cfg_data
  );

  // shadow configuration
  logic signed [31:0] up_vec [3];
  logic abs_mode;

  look_item_t  pending_items[$];
  matrix_row_t expected_rows[$];
  int  mismatches = 0;
  bit  sender_hold = 1'b0;
  longint cycles = 0;

  // ---- predictor ----
  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void unit_vector(input longint v [3], output longint u [3]);
    logic [63:0] mag [3];
    logic [63:0] mx, sum, n, q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
    n = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FRAC) + (n >> 1)) / n;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  // arithmetic shift floors toward minus infinity
  function automatic longint floor_frac(longint x);
    return x >>> FRAC;
  endfunction

  function automatic void predict_matrix(look_item_t it);
    longint eye [3], fwd [3], upv [3], upn [3], rt [3];
    matrix_row_t r;
    for (int i = 0; i < 3; i++) begin
      eye[i] = abs_mode ? longint'(it.tgt[i]) - longint'(it.abs_pos[i])
                        : (longint'(it.tgt[i]) - longint'(it.par[i])) - longint'(it.rel[i]);
      upv[i] = longint'(up_vec[i]);
    end
    unit_vector(eye, fwd);
    for (int i = 0; i < 3; i++) fwd[i] = -fwd[i];
    unit_vector(upv, upn);
    rt[0] = floor_frac(upn[1] * fwd[2] - upn[2] * fwd[1]);
    rt[1] = floor_frac(upn[2] * fwd[0] - upn[0] * fwd[2]);
    rt[2] = floor_frac(upn[0] * fwd[1] - upn[1] * fwd[0]);
    r.c3 = 0;
    r.last = 1'b0;
    r.row = ROW_RIGHT;
    r.c0 = 32'(rt[0]); r.c1 = 32'(rt[1]); r.c2 = 32'(rt[2]);
    expected_rows.push_back(r);
    r.row = ROW_UP;
    r.c0 = 32'(upn[0]); r.c1 = 32'(upn[1]); r.c2 = 32'(upn[2]);
    expected_rows.push_back(r);
    r.row = ROW_FWD;
    r.c0 = 32'(fwd[0]); r.c1 = 32'(fwd[1]); r.c2 = 32'(fwd[2]);
    expected_rows.push_back(r);
    r.row = ROW_TRANS;
    r.c3 = 32'sd1 <<< FRAC;
    r.last = 1'b1;
    if (abs_mode) begin
      r.c0 = it.abs_pos[0]; r.c1 = it.abs_pos[1]; r.c2 = it.abs_pos[2];
    end else begin
      r.c0 = it.rel[0]; r.c1 = it.rel[1]; r.c2 = it.rel[2];
    end
    expected_rows.push_back(r);
  endfunction

  // ---- stimulus helpers ----
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    endcase
  endfunction

  function automatic look_item_t rand_item();
    look_item_t it;
    for (int i = 0; i < 3; i++) begin
      it.tgt[i] = rand_coord();
      it.abs_pos[i] = rand_coord();
      it.par[i] = rand_coord();
      it.rel[i] = rand_coord();
    end
    return it;
  endfunction

  function automatic look_item_t fill_item(logic [31:0] t, logic [31:0] a,
                                           logic [31:0] p, logic [31:0] r);
    look_item_t it;
    for (int i = 0; i < 3; i++) begin
      it.tgt[i] = t; it.abs_pos[i] = a; it.par[i] = p; it.rel[i] = r;
    end
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_rows.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // valid stays high across back-to-back writes; set_config drops it
  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_UP_X:    up_vec[0] = val;
      CFG_UP_Y:    up_vec[1] = val;
      CFG_UP_Z:    up_vec[2] = val;
      CFG_USE_ABS: abs_mode = val[0];
    endcase
  endtask

  task automatic set_config(logic [31:0] ux, logic [31:0] uy, logic [31:0] uz, logic ab);
    wait_drained();
    write_reg(CFG_UP_X, ux);
    write_reg(CFG_UP_Y, uy);
    write_reg(CFG_UP_Z, uz);
    write_reg(CFG_USE_ABS, {$urandom_range(0, 1) ? 31'h7fffffff : 31'h0, ab});
    cfg_valid <= 1'b0;
  endtask

  // ---- driver: bursts with gaps ----
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_matrix(pending_items.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (!sender_hold && pending_items.size() > 0) begin
          look_item_t it;
          it = pending_items[0];
          target_x <= it.tgt[0]; target_y <= it.tgt[1]; target_z <= it.tgt[2];
          own_abs_x <= it.abs_pos[0]; own_abs_y <= it.abs_pos[1];
          own_abs_z <= it.abs_pos[2];
          parent_x <= it.par[0]; parent_y <= it.par[1]; parent_z <= it.par[2];
          rel_x <= it.rel[0]; rel_y <= it.rel[1]; rel_z <= it.rel[2];
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- receiver stall pattern, with one long hold-off ----
  // the hold-off starts inside the long phase so the pipeline fills up
  int long_stall = 0;
  bit long_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_stall > 0) begin
      long_stall <= long_stall - 1;
      out_ready <= 1'b0;
    end else if (!long_done && expected_rows.size() > 40 && pending_items.size() > 70) begin
      long_done <= 1'b1;
      long_stall <= 300;
      out_ready <= 1'b0;
    end else begin
      case (cycles[10:9])
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= $urandom_range(0, 3) != 0;
        2'd2:    out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= $urandom_range(0, 4) == 0;
      endcase
    end
  end

  // ---- monitor ----
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row transfer: row %0d", row_index);
      end else begin
        matrix_row_t e;
        e = expected_rows.pop_front();
        if (row_index !== e.row || col0 !== e.c0 || col1 !== e.c1 || col2 !== e.c2 ||
            col3 !== e.c3 || last_row !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row mismatch: exp %0d %h %h %h %h %b got %0d %h %h %h %h %b",
                     e.row, e.c0, e.c1, e.c2, e.c3, e.last,
                     row_index, col0, col1, col2, col3, last_row);
        end
      end
    end
  end

  // ---- run limit ----
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("look_at_matrix_builder_top_test NOT OK");
      $finish;
    end
  end

  // ---- stimulus sequence ----
  initial begin
    up_vec[0] = 0;
    up_vec[1] = 32'sd1 <<< FRAC;
    up_vec[2] = 0;
    abs_mode = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset configuration, extremes, zero eye vector, wide differences
    pending_items.push_back(fill_item(0, 0, 0, 0));
    pending_items.push_back(fill_item(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff));
    pending_items.push_back(fill_item(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000));
    pending_items.push_back(fill_item(32'h00010000, 0, 0, 0));
    pending_items.push_back(fill_item(1, 0, 0, 0));
    pending_items.push_back(fill_item(32'hffffffff, 32'hffffffff, 5, 7));
    for (int i = 0; i < 4; i++) pending_items.push_back(rand_item());

    // parent-relative mode, zero up vector
    set_config(0, 0, 0, 1'b0);
    pending_items.push_back(fill_item(32'h7fffffff, 3, 32'h80000000, 32'h80000000));
    pending_items.push_back(fill_item(32'h80000000, 3, 32'h7fffffff, 32'h7fffffff));
    pending_items.push_back(fill_item(10, 0, 4, 6));
    for (int i = 0; i < 3; i++) pending_items.push_back(rand_item());

    // extreme up vectors
    set_config(32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1);
    pending_items.push_back(fill_item(32'h7fffffff, 32'h80000000, 0, 0));
    for (int i = 0; i < 4; i++) pending_items.push_back(rand_item());
    set_config(32'h7fffffff, 32'h80000000, 1, 1'b0);
    for (int i = 0; i < 4; i++) pending_items.push_back(rand_item());

    // random phases: a long one that fills the pipeline under the hold-off,
    // one with the sender paused until the output drains
    for (int ph = 0; ph < 6; ph++) begin
      set_config(rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
      for (int i = 0; i < (ph == 1 ? 100 : 40); i++) begin
        look_item_t it;
        it = rand_item();
        pending_items.push_back(it);
      end
      if (ph == 2) begin
        while (pending_items.size() > 25) @(posedge clk);
        sender_hold = 1'b1;
        while (expected_rows.size() != 0 || in_valid) @(posedge clk);
        sender_hold = 1'b0;
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("look_at_matrix_builder_top_test OK");
    end else begin
      $display("look_at_matrix_builder_top_test NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+src
src/lamb_pkg.sv
src/lamb_norm.sv
src/lamb_cross.sv
src/look_at_matrix_builder_top.sv
verif/look_at_matrix_builder_top_test.sv
